// ===== src/spdb_pkg.sv =====
// shared types and constants for the sequenced playout delay buffer
package spdb_pkg;

  localparam int FIFO_DEPTH_DEF = 1024;
  localparam int MAX_FRAMES_DEF = 8;

  localparam int TIME_W  = 32;
  localparam int SEQ_W   = 16;
  localparam int COUNT_W = 9;
  localparam int INDEX_W = 8;
  localparam int BITS_W  = 6;
  localparam int FRAME_W = 32;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 1;
  localparam int DL_W    = 34;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 1'd1;

  localparam logic [CFG_W-1:0] PERIOD_RESET = 24'd16667;
  localparam logic [CFG_W-1:0] DELAY_RESET  = 24'd250000;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now;
    logic [SEQ_W-1:0]  seq;
    logic [BITS_W-1:0] bits;
  } cmd_t;

endpackage

// ===== src/spdb_ram.sv =====
// generic single write port ram with registered read
module spdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/spdb_front.sv =====
// front end: accepts items, computes the element sequence and queues commands
module spdb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [spdb_pkg::TIME_W-1:0]    time_now,
  input  logic [spdb_pkg::SEQ_W-1:0]     packet_sequence,
  input  logic [spdb_pkg::COUNT_W-1:0]   input_count,
  input  logic [spdb_pkg::INDEX_W-1:0]   element_index,
  input  logic [spdb_pkg::BITS_W-1:0]    input_bits,
  output logic                           cmd_valid,
  output spdb_pkg::cmd_t                 cmd,
  input  logic                           cmd_pop
);

  localparam int PW = spdb_pkg::CMDQ_PTR_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(spdb_pkg::CMDQ_DEPTH - 1);

  spdb_pkg::cmd_t           queue [spdb_pkg::CMDQ_DEPTH];
  logic [PW-1:0]            wr_ptr;
  logic [PW-1:0]            rd_ptr;
  logic [PW:0]              count;
  logic                     push;
  spdb_pkg::cmd_t           incoming;

  assign busy      = (count == (PW+1)'(spdb_pkg::CMDQ_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_comb begin
    incoming.op   = operation;
    incoming.now  = time_now;
    incoming.seq  = packet_sequence - spdb_pkg::SEQ_W'(input_count)
                    + spdb_pkg::SEQ_W'(element_index);
    incoming.bits = input_bits;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop && cmd_valid) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !(cmd_pop && cmd_valid)) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop && cmd_valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/spdb_back.sv =====
// back end: sequence check, word fifo and timed frame release
module spdb_back #(
  parameter int FIFO_DEPTH = spdb_pkg::FIFO_DEPTH_DEF,
  parameter int MAX_FRAMES = spdb_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  spdb_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic [spdb_pkg::CFG_W-1:0]    frame_period,
  input  logic [spdb_pkg::CFG_W-1:0]    playout_delay,
  output logic                          frame_valid,
  output logic [spdb_pkg::BITS_W-1:0]   frame_bits,
  output logic [spdb_pkg::FRAME_W-1:0]  frame_number,
  output logic                          frame_last
);

  localparam int AW    = $clog2(FIFO_DEPTH);
  localparam int PW    = $clog2(2 * FIFO_DEPTH);
  localparam int CW    = $clog2(MAX_FRAMES + 1);
  localparam int DW    = spdb_pkg::DL_W;
  localparam logic [PW:0] PTR_WRAP = (PW+1)'(2 * FIFO_DEPTH);
  localparam logic [PW:0] DEPTH_V  = (PW+1)'(FIFO_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * FIFO_DEPTH - 1);
  localparam logic [CW-1:0] MAX_V    = CW'(MAX_FRAMES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  logic                          state;
  logic                          armed;
  logic [DW-1:0]                 deadline;
  logic [spdb_pkg::SEQ_W-1:0]    expected;
  logic [spdb_pkg::FRAME_W-1:0]  released;
  logic [PW-1:0]                 head;
  logic [PW-1:0]                 tail;
  logic [CW-1:0]                 cnt;
  logic [spdb_pkg::TIME_W-1:0]   tick_now;
  logic                          rd_pending;
  logic [spdb_pkg::FRAME_W-1:0]  rd_number;

  logic [PW:0]                   level;
  logic                          fifo_empty;
  logic                          fifo_full;
  logic [AW-1:0]                 head_slot;
  logic [AW-1:0]                 tail_slot;
  logic [PW-1:0]                 head_next;
  logic [PW-1:0]                 tail_next;
  logic                          release_ok;
  logic                          do_add;
  logic                          do_write;
  logic [DW:0]                   step_sum;
  logic [DW-1:0]                 deadline_next;
  logic [DW-1:0]                 arm_deadline;
  logic [spdb_pkg::BITS_W-1:0]   ram_rdata;

  always_comb begin
    if (tail >= head) begin
      level = {1'b0, tail} - {1'b0, head};
    end else begin
      level = {1'b0, tail} + PTR_WRAP - {1'b0, head};
    end
    fifo_empty = (level == '0);
    fifo_full  = (level == DEPTH_V);
    head_slot  = ({1'b0, head} >= DEPTH_V) ? AW'({1'b0, head} - DEPTH_V) : AW'(head);
    tail_slot  = ({1'b0, tail} >= DEPTH_V) ? AW'({1'b0, tail} - DEPTH_V) : AW'(tail);
    head_next  = (head == PTR_LAST) ? '0 : head + 1'b1;
    tail_next  = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  end

  always_comb begin
    step_sum      = {1'b0, deadline} + (DW+1)'(frame_period);
    deadline_next = step_sum[DW] ? '1 : step_sum[DW-1:0];
    arm_deadline  = DW'(cmd.now) + DW'(({1'b0, frame_period} + 1'b1) >> 1)
                    + DW'(playout_delay);
  end

  assign cmd_pop    = (state == ST_IDLE) && cmd_valid;
  assign do_add     = cmd_pop && (cmd.op == spdb_pkg::OP_ADD);
  assign do_write   = do_add && (cmd.seq == expected) && !fifo_full;
  assign release_ok = (state == ST_TICK) && armed && !fifo_empty && (cnt < MAX_V)
                      && ({2'b00, tick_now} >= deadline);

  spdb_ram #(
    .WIDTH (spdb_pkg::BITS_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (tail_slot),
    .wr_data (cmd.bits),
    .rd_en   (release_ok),
    .rd_addr (head_slot),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      armed       <= 1'b0;
      deadline    <= '0;
      expected    <= '0;
      released    <= '0;
      head        <= '0;
      tail        <= '0;
      cnt         <= '0;
      rd_pending  <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= rd_pending;
      rd_pending  <= release_ok;
      unique case (state)
        ST_IDLE: begin
          if (do_add) begin
            if (!armed) begin
              armed    <= 1'b1;
              deadline <= arm_deadline;
            end
            if (do_write) begin
              tail     <= tail_next;
              expected <= expected + 1'b1;
            end
          end else if (cmd_pop) begin
            state <= ST_TICK;
            cnt   <= '0;
          end
        end
        ST_TICK: begin
          if (release_ok) begin
            head     <= head_next;
            released <= released + 1'b1;
            deadline <= deadline_next;
            cnt      <= cnt + 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      tick_now <= cmd.now;
    end
    if (release_ok) begin
      rd_number <= released;
    end
    frame_bits   <= ram_rdata;
    frame_number <= rd_number;
    frame_last   <= !release_ok;
  end

endmodule

// ===== src/sequenced_playout_delay_buffer_unit.sv =====
// top level of the sequenced playout delay buffer
//
// input channel: an item is taken on a clock edge with start high and busy low.
// operation add carries one packet element; its sequence is checked against
// the expected sequence; a matching word is written into the fifo if not full.
// the first add after reset arms the buffer and sets the first deadline.
// operation tick releases queued words, up to MAX_FRAMES, while time_now is
// at or past the deadline; each release moves the deadline by one period.
// items pass through a two-entry command queue; busy is high while it is full.
// an add is handled in the back end's idle state; a tick is taken in the idle
// state, then the tick state releases words in turn through the single fifo ram
// read port until it finds nothing more to release; no command is taken meanwhile.
// results: frame_valid strobes for one cycle per word, frame_last marks the
// last word of a tick; a released word passes the ram read register and then
// the output registers on its way to the ports. the receiver cannot stall.
// configuration: cfg_write with cfg_index and cfg_data writes frame_period or
// playout_delay at the clock edge; write only while the block is idle.
// reset (rst, synchronous) empties the fifo, disarms the buffer and restores
// the register defaults; fifo contents are not cleared.
module sequenced_playout_delay_buffer_unit #(
  parameter int FIFO_DEPTH = spdb_pkg::FIFO_DEPTH_DEF,
  parameter int MAX_FRAMES = spdb_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation,
  input  logic [spdb_pkg::TIME_W-1:0]      time_now,
  input  logic [spdb_pkg::SEQ_W-1:0]       packet_sequence,
  input  logic [spdb_pkg::COUNT_W-1:0]     input_count,
  input  logic [spdb_pkg::INDEX_W-1:0]     element_index,
  input  logic [spdb_pkg::BITS_W-1:0]      input_bits,
  input  logic                             cfg_write,
  input  logic [spdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spdb_pkg::CFG_W-1:0]       cfg_data,
  output logic                             frame_valid,
  output logic [spdb_pkg::BITS_W-1:0]      frame_bits,
  output logic [spdb_pkg::FRAME_W-1:0]     frame_number,
  output logic                             frame_last
);

  logic [spdb_pkg::CFG_W-1:0] frame_period;
  logic [spdb_pkg::CFG_W-1:0] playout_delay;
  logic                       cmd_valid;
  logic                       cmd_pop;
  spdb_pkg::cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period  <= spdb_pkg::PERIOD_RESET;
      playout_delay <= spdb_pkg::DELAY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spdb_pkg::CFG_PERIOD: frame_period  <= cfg_data;
        spdb_pkg::CFG_DELAY:  playout_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  spdb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .time_now        (time_now),
    .packet_sequence (packet_sequence),
    .input_count     (input_count),
    .element_index   (element_index),
    .input_bits      (input_bits),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  spdb_back #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .frame_period  (frame_period),
    .playout_delay (playout_delay),
    .frame_valid   (frame_valid),
    .frame_bits    (frame_bits),
    .frame_number  (frame_number),
    .frame_last    (frame_last)
  );

endmodule
